[rtl/core/eitp_pkg.sv]
// Shared types and constants for the Ethernet/IPv4/TCP payload filter.
// No dependencies; imported by every module of the block.
package eitp_pkg;

    localparam int LengthBits   = 16;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrBits = $clog2(QueueDepth);
    localparam int QueueCntBits = $clog2(QueueDepth + 1);

    localparam logic [16:0] LenMax     = 17'((17'd1 << LengthBits) - 17'd1);
    localparam logic [15:0] EthTypeIpv4 = 16'h0800;
    localparam logic [15:0] EthHdrBytes = 16'd14;
    localparam logic [15:0] MinCapture  = 16'd34;
    localparam logic [3:0]  IpVersion4  = 4'd4;
    localparam logic [3:0]  MinHdrWords = 4'd5;
    localparam logic [7:0]  ProtoTcp    = 8'd6;
    localparam logic [15:0] PortReset   = 16'd102;

    localparam logic [0:0]  AddrMatchPort = 1'b0;

    typedef enum logic [4:0] {
        PH_ETH     = 5'b00001,
        PH_IP      = 5'b00010,
        PH_TCP     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        phase_t phase;
        logic   drop;
    } front_status_t;

endpackage

[rtl/core/eth_ipv4_tcp_port_payload_filter.sv]
// Top level of the Ethernet/IPv4/TCP source-port payload filter.
// Depends on eitp_pkg, eitp_front, eitp_queue and eitp_back.
//
//   channel   dir  handshake          contents
//   s_axis    in   tvalid/tready      frame bytes, tlast on the final byte
//   m_axis    out  tvalid/tready      payload bytes, tlast closes a segment
//   apb       in   psel/penable       match_source_port at address 0
//
// One frame byte per cycle; the parser takes a byte every cycle the queue has room.
// A payload byte passes through a queue slot and then the output register on its way to m_axis.
// s_axis_tready drops only while the four-entry queue is full.
// Reset clears the parser, the queue and the output register; the port resets to 102.
module eth_ipv4_tcp_port_payload_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] frame_byte, [23:8] capture_length
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import eitp_pkg::*;

    logic                    accept;
    logic                    full;
    logic                    push_valid;
    beat_t                   push_beat;
    front_status_t           status;
    logic                    head_valid;
    beat_t                   head_beat;
    logic                    pop;
    logic [QueueCntBits-1:0] level;
    logic [15:0]             match_reg;

    assign pready        = 1'b1;
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign prdata        = (paddr == AddrMatchPort) ? {16'b0, match_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= PortReset;
        else if (psel && penable && pwrite && pready && paddr == AddrMatchPort)
            match_reg <= pwdata[15:0];
    end

    eitp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .frame_byte        (s_axis_tdata[7:0]),
        .frame_last        (s_axis_tlast),
        .capture_length    (s_axis_tdata[23:8]),
        .match_source_port (match_reg),
        .push_valid        (push_valid),
        .push_beat         (push_beat),
        .status            (status)
    );

    eitp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_beat  (push_beat),
        .pop        (pop),
        .head_valid (head_valid),
        .head_beat  (head_beat),
        .full       (full),
        .level      (level)
    );

    eitp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_beat     (head_beat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> accept)
        else $error("payload beat pushed without an accepted frame beat");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QueueCntBits'(QueueDepth))
        else $error("queue level beyond depth");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> status.phase == PH_ETH && !status.drop)
        else $error("parser not cleared after last frame beat");

    a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> status.phase == PH_PAYLOAD && !status.drop)
        else $error("beat pushed outside payload phase");
`endif

endmodule

[rtl/core/eitp_front.sv]
// Front end: header parser and classifier, one frame byte per beat.
// Depends on eitp_pkg; pushes payload beats into eitp_queue.
module eitp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_last,
    input  logic [15:0]            capture_length,
    input  logic [15:0]            match_source_port,
    output logic                   push_valid,
    output eitp_pkg::beat_t        push_beat,
    output eitp_pkg::front_status_t status
);
    import eitp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [15:0] tl_reg, tl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [5:0]  thb_reg, thb_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] left_reg, left_next;
    logic        drop_reg, drop_next;
    logic        emit;

    logic [15:0] rel_ip;
    logic [15:0] rel_tcp;

    assign rel_ip  = offset_reg - EthHdrBytes;
    assign rel_tcp = offset_reg - EthHdrBytes - {10'b0, ihb_reg};

    always_comb
    begin
        logic [15:0] et;
        logic [15:0] tl;
        logic [15:0] avail;
        logic [5:0]  thb;
        logic [15:0] dec;
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        ethertype_next = ethertype_reg;
        ihb_next       = ihb_reg;
        tl_next        = tl_reg;
        proto_next     = proto_reg;
        thb_next       = thb_reg;
        sport_next     = sport_reg;
        left_next      = left_reg;
        drop_next      = drop_reg;
        emit           = 1'b0;
        push_beat.data = frame_byte;
        push_beat.last = 1'b0;
        et    = {ethertype_reg[15:8], frame_byte};
        tl    = {tl_reg[15:8], frame_byte};
        avail = tl_reg - {10'b0, ihb_reg};
        thb   = {frame_byte[7:4], 2'b00};
        dec   = left_reg - 16'd1;
        if (!drop_reg)
        begin
            case (phase_reg)
                PH_ETH:
                begin
                    if (offset_reg == 16'd0 && {1'b0, capture_length} > LenMax)
                        drop_next = 1'b1;
                    if (offset_reg == 16'd12)
                        ethertype_next = {frame_byte, 8'h00};
                    if (offset_reg == 16'd13)
                    begin
                        ethertype_next = et;
                        if (et != EthTypeIpv4 || capture_length < MinCapture)
                            drop_next = 1'b1;
                        else
                            phase_next = PH_IP;
                    end
                end
                PH_IP:
                begin
                    if (rel_ip == 16'd0)
                    begin
                        if (frame_byte[7:4] != IpVersion4 || frame_byte[3:0] < MinHdrWords)
                            drop_next = 1'b1;
                        else
                            ihb_next = {frame_byte[3:0], 2'b00};
                    end
                    else if (rel_ip == 16'd2)
                    begin
                        tl_next = {frame_byte, 8'h00};
                    end
                    else if (rel_ip == 16'd3)
                    begin
                        tl_next = tl;
                        if (capture_length >= EthHdrBytes
                            && ({1'b0, tl} + {1'b0, EthHdrBytes}) > {1'b0, capture_length})
                            drop_next = 1'b1;
                    end
                    else if (rel_ip == 16'd9)
                    begin
                        proto_next = frame_byte;
                        if (frame_byte != ProtoTcp)
                            drop_next = 1'b1;
                    end
                    if (!drop_next && ({1'b0, rel_ip} + 17'd1) == {11'b0, ihb_reg})
                    begin
                        if ({1'b0, tl_reg} < ({11'b0, ihb_reg} + 17'd20))
                            drop_next = 1'b1;
                        else
                            phase_next = PH_TCP;
                    end
                end
                PH_TCP:
                begin
                    if (rel_tcp == 16'd0)
                    begin
                        sport_next = {frame_byte, 8'h00};
                    end
                    else if (rel_tcp == 16'd1)
                    begin
                        sport_next = {sport_reg[15:8], frame_byte};
                    end
                    else if (rel_tcp == 16'd12)
                    begin
                        if (frame_byte[7:4] < MinHdrWords)
                            drop_next = 1'b1;
                        else
                        begin
                            thb_next = thb;
                            if ({10'b0, thb} >= avail)
                                drop_next = 1'b1;
                            else if (sport_reg != match_source_port)
                                drop_next = 1'b1;
                            else
                                left_next = avail - {10'b0, thb};
                        end
                    end
                    if (!drop_next && ({1'b0, rel_tcp} + 17'd1) == {11'b0, thb_reg})
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    left_next      = dec;
                    emit           = 1'b1;
                    push_beat.last = (dec == 16'd0) || frame_last;
                    if (dec == 16'd0)
                        phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
        if (frame_last)
        begin
            phase_next     = PH_ETH;
            offset_next    = 16'd0;
            ethertype_next = 16'd0;
            ihb_next       = 6'd0;
            tl_next        = 16'd0;
            proto_next     = 8'd0;
            thb_next       = 6'd0;
            sport_next     = 16'd0;
            left_next      = 16'd0;
            drop_next      = 1'b0;
        end
        else if (offset_reg < LenMax[15:0])
        begin
            offset_next = offset_reg + 16'd1;
        end
    end

    assign push_valid    = accept && emit;
    assign status.phase  = phase_reg;
    assign status.drop   = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ETH;
            offset_reg    <= 16'd0;
            ethertype_reg <= 16'd0;
            ihb_reg       <= 6'd0;
            tl_reg        <= 16'd0;
            proto_reg     <= 8'd0;
            thb_reg       <= 6'd0;
            sport_reg     <= 16'd0;
            left_reg      <= 16'd0;
            drop_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            ethertype_reg <= ethertype_next;
            ihb_reg       <= ihb_next;
            tl_reg        <= tl_next;
            proto_reg     <= proto_next;
            thb_reg       <= thb_next;
            sport_reg     <= sport_next;
            left_reg      <= left_next;
            drop_reg      <= drop_next;
        end
    end

endmodule

[rtl/core/eitp_queue.sv]
// Short payload beat queue between parser and output stage.
// Depends on eitp_pkg for depth and beat type.
module eitp_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  eitp_pkg::beat_t                   push_beat,
    input  logic                              pop,
    output logic                              head_valid,
    output eitp_pkg::beat_t                   head_beat,
    output logic                              full,
    output logic [eitp_pkg::QueueCntBits-1:0] level
);
    import eitp_pkg::*;

    beat_t                   slot_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg;
    logic [QueuePtrBits-1:0] rd_ptr_reg;
    logic [QueueCntBits-1:0] count_reg, count_next;

    assign head_valid = count_reg != '0;
    assign head_beat  = slot_reg[rd_ptr_reg];
    assign full       = count_reg == QueueCntBits'(QueueDepth);
    assign level      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QueueCntBits'(1);
        else if (pop && !push)
            count_next = count_reg - QueueCntBits'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QueuePtrBits'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QueuePtrBits'(1);
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/eitp_back.sv]
// Back end: output register that drives the master stream.
// Depends on eitp_pkg; drains eitp_queue.
module eitp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  eitp_pkg::beat_t head_beat,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);
    import eitp_pkg::*;

    logic  valid_reg;
    beat_t beat_reg;

    assign pop           = head_valid && (!valid_reg || m_axis_tready);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = beat_reg.data;
    assign m_axis_tlast  = beat_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_axis_tready)
            valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            beat_reg <= head_beat;
    end

endmodule
